/* rtl/core/multigrid_full_weighting_restrict_assert.svh */
// Assertion macros for the full-weighting restriction block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef MULTIGRID_FULL_WEIGHTING_RESTRICT_ASSERT_SVH
`define MULTIGRID_FULL_WEIGHTING_RESTRICT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define MGFW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MGFW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mgfw_pkg.sv */
// Shared types and constants for the full-weighting restriction block.
// No dependencies; used by every module of the block except mgfw_ram and mgfw_checker.
`timescale 1ns / 1ps
`default_nettype none

package mgfw_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_WIDTH   = 64;
	localparam int DEF_MAX_HEIGHT  = 64;
	localparam int DEF_SAMPLE_BITS = 32;

	// Fixed field widths
	localparam int COORD_W    = 7;
	localparam int VALUE_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FINE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FINE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COARSEN_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COARSEN_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_X_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_X_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_Y_LOW  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_Y_HIGH = 3'd7;

	// Register reset values
	localparam logic [COORD_W-1:0] RST_FINE_WIDTH  = 7'd64;
	localparam logic [COORD_W-1:0] RST_FINE_HEIGHT = 7'd64;

	// Stencil tap position along one axis
	typedef enum logic [1:0] {
		TAP_LO,
		TAP_MID,
		TAP_HI
	} tap_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wr;        // store the load beat's sample
		logic cap;       // capture the compute beat's coordinates
		logic setup;     // register taps and error, clear accumulator
		logic rd;        // read one stencil sample
		tap_t tap_x;
		tap_t tap_y;
		logic out_load;  // move the result into the output register
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic err;       // coarse point lies outside the coarse grid
	} ctl_sts_t;

	// Next tap in x-fastest scan order
	function automatic tap_t tap_next(input tap_t t);
		tap_t r;
		unique case (t)
			TAP_LO:  r = TAP_MID;
			TAP_MID: r = TAP_HI;
			default: r = TAP_LO;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/mgfw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mgfw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/mgfw_axis.sv */
// Tap index logic for one grid axis: clamps the size, checks the coarse
// index and yields the three 0-based fine indices. Uses mgfw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgfw_axis #(
	parameter int MAX_N = mgfw_pkg::DEF_MAX_WIDTH,
	parameter int IW    = $clog2(MAX_N)
) (
	input  wire logic [mgfw_pkg::COORD_W-1:0] c,
	input  wire logic [mgfw_pkg::COORD_W-1:0] size,
	input  wire logic                         coarsen,
	input  wire logic                         wrap_low,
	input  wire logic                         wrap_high,
	output logic      [IW-1:0]                t_lo,
	output logic      [IW-1:0]                t_mid,
	output logic      [IW-1:0]                t_hi,
	output logic                              err
);

	// One spare bit so that 2*c never overflows
	localparam int NB = (($clog2(MAX_N + 1) > mgfw_pkg::COORD_W) ?
		$clog2(MAX_N + 1) : mgfw_pkg::COORD_W) + 1;
	localparam logic [NB-1:0] MAX_V = NB'(MAX_N);
	localparam logic [NB-1:0] ONE   = NB'(1);
	localparam logic [NB-1:0] TWO   = NB'(2);
	localparam logic [NB-1:0] THREE = NB'(3);

	logic [NB-1:0] cv, sv, n, nc, ctr, lo, mid, hi;

	always_comb begin
		cv = NB'(c);
		sv = NB'(size);
		// clamp the size register to 3..MAX_N
		priority if (sv < THREE) begin
			n = THREE;
		end else if (sv > MAX_V) begin
			n = MAX_V;
		end else begin
			n = sv;
		end
		nc  = coarsen ? ((n + ONE) >> 1) : n;
		err = (cv == '0) || (cv > nc);
		// interior centre, 0-based
		ctr = coarsen ? ((cv << 1) - TWO) : (cv - ONE);
		priority if (cv == ONE) begin
			lo  = wrap_low ? (n - TWO) : ONE;
			mid = '0;
			hi  = ONE;
		end else if (cv == nc) begin
			lo  = n - TWO;
			mid = n - ONE;
			hi  = wrap_high ? ONE : (n - TWO);
		end else begin
			lo  = ctr - ONE;
			mid = ctr;
			hi  = ctr + ONE;
		end
		t_lo  = lo[IW-1:0];
		t_mid = mid[IW-1:0];
		t_hi  = hi[IW-1:0];
	end

endmodule

`default_nettype wire

/* rtl/core/mgfw_datapath.sv */
// Datapath: configuration registers, fine grid memory, tap registers,
// weighted accumulator and result register. Uses mgfw_pkg, mgfw_ram,
// mgfw_axis.
`timescale 1ns / 1ps
`default_nettype none

module mgfw_datapath #(
	parameter int MAX_WIDTH   = mgfw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = mgfw_pkg::DEF_MAX_HEIGHT,
	parameter int SAMPLE_BITS = mgfw_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mgfw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mgfw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [mgfw_pkg::COORD_W-1:0]    col,
	input  wire logic [mgfw_pkg::COORD_W-1:0]    row,
	input  wire logic [mgfw_pkg::VALUE_W-1:0]    sample,
	input  wire mgfw_pkg::ctl_cmd_t              cmd,
	output mgfw_pkg::ctl_sts_t                   sts,
	output logic      [mgfw_pkg::VALUE_W-1:0]    coarse_value,
	output logic                                 index_error
);

	localparam int XIW   = $clog2(MAX_WIDTH);
	localparam int YIW   = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int ACC_W = SAMPLE_BITS + 4;
	localparam int XNW   = ($clog2(MAX_WIDTH + 1) > mgfw_pkg::COORD_W) ?
		$clog2(MAX_WIDTH + 1) : mgfw_pkg::COORD_W;
	localparam int YNW   = ($clog2(MAX_HEIGHT + 1) > mgfw_pkg::COORD_W) ?
		$clog2(MAX_HEIGHT + 1) : mgfw_pkg::COORD_W;
	localparam logic [XNW-1:0] MAX_X  = XNW'(MAX_WIDTH);
	localparam logic [YNW-1:0] MAX_Y  = YNW'(MAX_HEIGHT);
	localparam logic [AW-1:0]  STRIDE = AW'(MAX_WIDTH);

	// Configuration registers
	logic [mgfw_pkg::COORD_W-1:0] fine_width_q, fine_height_q;
	logic coarsen_x_q, coarsen_y_q;
	logic wrap_x_low_q, wrap_x_high_q, wrap_y_low_q, wrap_y_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_width_q  <= mgfw_pkg::RST_FINE_WIDTH;
			fine_height_q <= mgfw_pkg::RST_FINE_HEIGHT;
			coarsen_x_q   <= 1'b1;
			coarsen_y_q   <= 1'b1;
			wrap_x_low_q  <= 1'b0;
			wrap_x_high_q <= 1'b0;
			wrap_y_low_q  <= 1'b0;
			wrap_y_high_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mgfw_pkg::REG_FINE_WIDTH:  fine_width_q  <= cfg_data;
				mgfw_pkg::REG_FINE_HEIGHT: fine_height_q <= cfg_data;
				mgfw_pkg::REG_COARSEN_X:   coarsen_x_q   <= cfg_data[0];
				mgfw_pkg::REG_COARSEN_Y:   coarsen_y_q   <= cfg_data[0];
				mgfw_pkg::REG_WRAP_X_LOW:  wrap_x_low_q  <= cfg_data[0];
				mgfw_pkg::REG_WRAP_X_HIGH: wrap_x_high_q <= cfg_data[0];
				mgfw_pkg::REG_WRAP_Y_LOW:  wrap_y_low_q  <= cfg_data[0];
				mgfw_pkg::REG_WRAP_Y_HIGH: wrap_y_high_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Load address; loads outside the memory are dropped
	logic [XNW-1:0]     col_w;
	logic [YNW-1:0]     row_w;
	logic [XIW-1:0]     wx;
	logic [YIW-1:0]     wy;
	logic               ld_ok;
	logic [AW-1:0]      waddr;
	logic [63:0]        smp_ext;
	logic [SAMPLE_BITS-1:0] wdata;

	always_comb begin
		col_w   = XNW'(col);
		row_w   = YNW'(row);
		ld_ok   = (col_w != '0) && (col_w <= MAX_X) && (row_w != '0) && (row_w <= MAX_Y);
		wx      = XIW'(col_w - XNW'(1));
		wy      = YIW'(row_w - YNW'(1));
		waddr   = AW'(wy) * STRIDE + AW'(wx);
		smp_ext = 64'(sample);
		wdata   = smp_ext[SAMPLE_BITS-1:0];
	end

	// Coordinates of the compute beat
	logic [mgfw_pkg::COORD_W-1:0] col_q, row_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			col_q <= col;
			row_q <= row;
		end
	end

	// Tap index generation per axis
	logic [XIW-1:0] ax_lo, ax_mid, ax_hi;
	logic [YIW-1:0] ay_lo, ay_mid, ay_hi;
	logic           ax_err, ay_err;

	mgfw_axis #(.MAX_N(MAX_WIDTH), .IW(XIW)) u_axis_x (
		.c(col_q), .size(fine_width_q), .coarsen(coarsen_x_q),
		.wrap_low(wrap_x_low_q), .wrap_high(wrap_x_high_q),
		.t_lo(ax_lo), .t_mid(ax_mid), .t_hi(ax_hi), .err(ax_err)
	);

	mgfw_axis #(.MAX_N(MAX_HEIGHT), .IW(YIW)) u_axis_y (
		.c(row_q), .size(fine_height_q), .coarsen(coarsen_y_q),
		.wrap_low(wrap_y_low_q), .wrap_high(wrap_y_high_q),
		.t_lo(ay_lo), .t_mid(ay_mid), .t_hi(ay_hi), .err(ay_err)
	);

	assign sts.err = ax_err || ay_err;

	// Tap registers
	logic [XIW-1:0] tx_lo_q, tx_mid_q, tx_hi_q;
	logic [YIW-1:0] ty_lo_q, ty_mid_q, ty_hi_q;
	logic           err_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			tx_lo_q  <= ax_lo;
			tx_mid_q <= ax_mid;
			tx_hi_q  <= ax_hi;
			ty_lo_q  <= ay_lo;
			ty_mid_q <= ay_mid;
			ty_hi_q  <= ay_hi;
			err_q    <= sts.err;
		end
	end

	// Read address of the current tap
	logic [XIW-1:0] rx;
	logic [YIW-1:0] ry;
	logic [AW-1:0]  raddr;

	always_comb begin
		unique case (cmd.tap_x)
			mgfw_pkg::TAP_LO:  rx = tx_lo_q;
			mgfw_pkg::TAP_MID: rx = tx_mid_q;
			default:           rx = tx_hi_q;
		endcase
		unique case (cmd.tap_y)
			mgfw_pkg::TAP_LO:  ry = ty_lo_q;
			mgfw_pkg::TAP_MID: ry = ty_mid_q;
			default:           ry = ty_hi_q;
		endcase
		raddr = AW'(ry) * STRIDE + AW'(rx);
	end

	logic [SAMPLE_BITS-1:0] rdata;

	mgfw_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_grid (
		.clk(clk),
		.we(cmd.wr && ld_ok),
		.waddr(waddr),
		.wdata(wdata),
		.re(cmd.rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Read data arrives in the cycle after the address; tap codes follow it
	logic           acc_en_s1;
	mgfw_pkg::tap_t tap_x_s1, tap_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
			tap_x_s1  <= mgfw_pkg::TAP_LO;
			tap_y_s1  <= mgfw_pkg::TAP_LO;
		end else begin
			acc_en_s1 <= cmd.rd;
			tap_x_s1  <= cmd.tap_x;
			tap_y_s1  <= cmd.tap_y;
		end
	end

	// Weighted accumulate: weight is 1, 2 or 4 as a left shift
	logic signed [ACC_W-1:0] term, acc_q;
	logic [1:0]              wsh;

	always_comb begin
		wsh  = 2'((tap_x_s1 == mgfw_pkg::TAP_MID)) + 2'((tap_y_s1 == mgfw_pkg::TAP_MID));
		term = ACC_W'(signed'(rdata)) <<< wsh;
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			acc_q <= '0;
		end else if (acc_en_s1) begin
			acc_q <= acc_q + term;
		end
	end

	// Floor by 16, keep SAMPLE_BITS, present as a 32-bit field
	logic signed [ACC_W-1:0] quo;
	logic [SAMPLE_BITS-1:0]  quo_s;
	logic [63:0]             quo_ext;

	always_comb begin
		quo     = acc_q >>> 4;
		quo_s   = quo[SAMPLE_BITS-1:0];
		quo_ext = 64'(quo_s);
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			coarse_value <= err_q ? '0 : quo_ext[mgfw_pkg::VALUE_W-1:0];
			index_error  <= err_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/mgfw_ctrl.sv */
// Controller state machine: input handshake, tap read sequence and
// output valid. Uses mgfw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgfw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_action,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output mgfw_pkg::ctl_cmd_t      cmd,
	input  wire mgfw_pkg::ctl_sts_t sts
);

	mgfw_pkg::state_t state_q, state_d;
	mgfw_pkg::tap_t   tap_x_q, tap_y_q;
	logic             m_tvalid_q;
	logic             out_free, last_tap;

	assign out_free = !m_tvalid_q || m_tready;
	assign last_tap = (tap_x_q == mgfw_pkg::TAP_HI) && (tap_y_q == mgfw_pkg::TAP_HI);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mgfw_pkg::ST_IDLE: begin
				if (s_tvalid && s_action) state_d = mgfw_pkg::ST_SETUP;
			end
			mgfw_pkg::ST_SETUP: begin
				state_d = sts.err ? mgfw_pkg::ST_DONE : mgfw_pkg::ST_READ;
			end
			mgfw_pkg::ST_READ: begin
				if (last_tap) state_d = mgfw_pkg::ST_DRAIN;
			end
			mgfw_pkg::ST_DRAIN: begin
				state_d = mgfw_pkg::ST_DONE;
			end
			mgfw_pkg::ST_DONE: begin
				if (out_free) state_d = mgfw_pkg::ST_IDLE;
			end
			default: state_d = mgfw_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready     = 1'b0;
		cmd.wr       = 1'b0;
		cmd.cap      = 1'b0;
		cmd.setup    = 1'b0;
		cmd.rd       = 1'b0;
		cmd.tap_x    = tap_x_q;
		cmd.tap_y    = tap_y_q;
		cmd.out_load = 1'b0;
		unique case (state_q)
			mgfw_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.wr   = s_tvalid && !s_action;
				cmd.cap  = s_tvalid && s_action;
			end
			mgfw_pkg::ST_SETUP: cmd.setup = 1'b1;
			mgfw_pkg::ST_READ:  cmd.rd = 1'b1;
			mgfw_pkg::ST_DRAIN: ;
			mgfw_pkg::ST_DONE:  cmd.out_load = out_free;
			default: ;
		endcase
	end

	// State, tap counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mgfw_pkg::ST_IDLE;
			tap_x_q    <= mgfw_pkg::TAP_LO;
			tap_y_q    <= mgfw_pkg::TAP_LO;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.setup) begin
				tap_x_q <= mgfw_pkg::TAP_LO;
				tap_y_q <= mgfw_pkg::TAP_LO;
			end else if (cmd.rd) begin
				tap_x_q <= mgfw_pkg::tap_next(tap_x_q);
				if (tap_x_q == mgfw_pkg::TAP_HI) tap_y_q <= mgfw_pkg::tap_next(tap_y_q);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

/* rtl/core/multigrid_full_weighting_restrict.sv */
// Top level of the 2D full-weighting restriction block.
// Uses mgfw_pkg, mgfw_ctrl and mgfw_datapath.
//
// Usage:
//  - Input stream (s_*): s_tuser selects the beat kind, 0 loads a fine
//    sample at (col, row), 1 asks for the coarse point (col, row), 1-based.
//  - Output stream (m_*): one beat per compute beat, none per load beat.
//    m_tuser flags a coarse point outside the coarse grid (value then 0).
//  - Configuration: cfg_we writes cfg_data into register cfg_index at the
//    clock edge; write only while no compute beat is in flight.
//  - Loads can stream back to back, one per cycle, while s_tready is high.
//  - A compute beat runs setup, nine reads of the single grid memory read
//    port (one stencil tap per cycle) and a drain step for the last
//    accumulate; the next beat is taken in the cycle after the result is
//    registered. An outside point skips the reads and the drain step.
//  - A finished result waits in the output register; new loads are taken
//    while it waits. A compute result stays in its last stage until the
//    output register is free, holding s_tready low meanwhile.
//  - Reset (arst_n low) clears control and sets the configuration registers
//    to their reset values; grid contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module multigrid_full_weighting_restrict #(
	parameter int MAX_WIDTH   = mgfw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = mgfw_pkg::DEF_MAX_HEIGHT,
	parameter int SAMPLE_BITS = mgfw_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_we,
	input  wire logic [mgfw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mgfw_pkg::CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [47:0]                     s_tdata,  // col[6:0], row[13:7], sample[45:14]
	input  wire logic                            s_tuser,  // action
	// output stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [31:0]                     m_tdata,  // coarse_value[31:0]
	output logic                                 m_tuser   // index_error
);

	mgfw_pkg::ctl_cmd_t cmd;
	mgfw_pkg::ctl_sts_t sts;

	mgfw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_action(s_tuser),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd(cmd),
		.sts(sts)
	);

	mgfw_datapath #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.col(s_tdata[6:0]),
		.row(s_tdata[13:7]),
		.sample(s_tdata[45:14]),
		.cmd(cmd),
		.sts(sts),
		.coarse_value(m_tdata),
		.index_error(m_tuser)
	);

endmodule

`default_nettype wire

/* rtl/core/mgfw_checker.sv */
// Port-level checks for the full-weighting restriction block, bound to
// the top level. Uses multigrid_full_weighting_restrict_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "multigrid_full_weighting_restrict_assert.svh"

module mgfw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser
);

	// a stalled result beat holds
	`MGFW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

	// an outside coarse point reports zero
	`MGFW_ASSERT_SAME(a_err_zero, m_tvalid && m_tuser, m_tdata == 32'd0, "index error with nonzero value")

	// a compute beat makes the block busy, a load beat does not
	`MGFW_ASSERT_NEXT(a_busy, s_tvalid && s_tready && s_tuser, !s_tready, "input still ready after compute beat")
	`MGFW_ASSERT_NEXT(a_load_free, s_tvalid && s_tready && !s_tuser, s_tready, "input stalled after load beat")

	// a new result is registered only from the busy part of the sequence
	`MGFW_ASSERT_SAME(a_new_result, $rose(m_tvalid), !$past(s_tready), "result appeared while idle")

endmodule

bind multigrid_full_weighting_restrict mgfw_checker u_mgfw_checker (.*);

`default_nettype wire

/* verif/multigrid_full_weighting_restrict_test.sv */
// Self-checking testbench for the 2D full-weighting restriction block.
// Needs mgfw_pkg and multigrid_full_weighting_restrict; reads no files.
`timescale 1ns / 1ps

module multigrid_full_weighting_restrict_test;

	localparam int MAX_W        = mgfw_pkg::DEF_MAX_WIDTH;
	localparam int MAX_H        = mgfw_pkg::DEF_MAX_HEIGHT;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int BEATS_PER_PHASE = 130;
	localparam int NUM_PHASES   = 8;

	// action codes carried in s_tuser
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	typedef struct packed {
		logic [31:0] value;
		logic        err;
	} coarse_t;

	typedef struct packed {
		logic        act;
		logic [6:0]  x;
		logic [6:0]  y;
		logic [31:0] smp;
		logic        known;
		logic [31:0] k_value;
		logic        k_err;
	} dir_row_t;

	typedef struct packed {
		logic [6:0] fw;
		logic [6:0] fh;
		logic       cx;
		logic       cy;
		logic       wxl;
		logic       wxh;
		logic       wyl;
		logic       wyh;
	} setting_t;

	typedef enum int {
		RX_FULL,
		RX_HALF,
		RX_SLOW
	} rx_mode_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [mgfw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mgfw_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [47:0]                     s_tdata;  // col[6:0], row[13:7], sample[45:14]
	logic                            s_tuser;  // action
	logic                            m_tvalid;
	logic                            m_tready;
	logic [31:0]                     m_tdata;  // coarse_value[31:0]
	logic                            m_tuser;  // index_error

	multigrid_full_weighting_restrict u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Shadow copy of the grid and the registers
	logic [31:0] fine_store [MAX_W*MAX_H];
	bit          loaded     [MAX_W*MAX_H];
	logic [6:0]  cfg_fw = mgfw_pkg::RST_FINE_WIDTH;
	logic [6:0]  cfg_fh = mgfw_pkg::RST_FINE_HEIGHT;
	logic        cfg_cx = 1'b1, cfg_cy = 1'b1;
	logic        cfg_wxl = 1'b0, cfg_wxh = 1'b0, cfg_wyl = 1'b0, cfg_wyh = 1'b0;

	coarse_t pending_coarse [$];
	int      fail_count = 0;
	int      beats_counted = 0;
	int      burst_left = 0;
	bit      hold_req = 1'b0;

	// Directed beats, checked against typed values where marked known
	dir_row_t directed_rows [26] = '{
		'{ACT_LOAD,    7'd1,   7'd1,   32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd2,   7'd1,   32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd1,   7'd2,   32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd2,   7'd2,   32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
		'{ACT_COMPUTE, 7'd1,   7'd1,   32'h0,         1'b1, 32'h7FFF_FFFF, 1'b0},
		'{ACT_LOAD,    7'd1,   7'd1,   32'h8000_0000, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd2,   7'd1,   32'h8000_0000, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd1,   7'd2,   32'h8000_0000, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd2,   7'd2,   32'h8000_0000, 1'b0, 32'h0,         1'b0},
		'{ACT_COMPUTE, 7'd1,   7'd1,   32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0},
		// a lone -1 at the centre floors to -1, not 0
		'{ACT_LOAD,    7'd1,   7'd1,   32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd2,   7'd1,   32'h0,         1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd1,   7'd2,   32'h0,         1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd2,   7'd2,   32'h0,         1'b0, 32'h0,         1'b0},
		'{ACT_COMPUTE, 7'd1,   7'd1,   32'h0,         1'b1, 32'hFFFF_FFFF, 1'b0},
		// coarse points off the 32x32 coarse grid
		'{ACT_COMPUTE, 7'd0,   7'd1,   32'h0,         1'b1, 32'h0,         1'b1},
		'{ACT_COMPUTE, 7'd1,   7'd0,   32'h0,         1'b1, 32'h0,         1'b1},
		'{ACT_COMPUTE, 7'd33,  7'd5,   32'h0,         1'b1, 32'h0,         1'b1},
		'{ACT_COMPUTE, 7'd5,   7'd33,  32'h0,         1'b1, 32'h0,         1'b1},
		'{ACT_COMPUTE, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1, 32'h0,         1'b1},
		'{ACT_LOAD,    7'd64,  7'd64,  32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
		// loads off the grid must leave the store alone
		'{ACT_LOAD,    7'd65,  7'd1,   32'h1234_5678, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd0,   7'd1,   32'h1234_5678, 1'b0, 32'h0,         1'b0},
		'{ACT_LOAD,    7'd127, 7'd127, 32'h1234_5678, 1'b0, 32'h0,         1'b0},
		'{ACT_COMPUTE, 7'd1,   7'd1,   32'h0,         1'b1, 32'hFFFF_FFFF, 1'b0},
		'{ACT_COMPUTE, 7'd32,  7'd32,  32'h0,         1'b0, 32'h0,         1'b0}
	};

	// Register settings for each phase but the last; sizes 0 and 127 exercise the clamp
	setting_t phase_settings [NUM_PHASES-1] = '{
		'{7'd64,  7'd64,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{7'd3,   7'd3,   1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
		'{7'd127, 7'd0,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1},
		'{7'd0,   7'd127, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0},
		'{7'd64,  7'd64,  1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
		'{7'd17,  7'd9,   1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
		'{7'd8,   7'd31,  1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}
	};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic int clamp_dim(logic [6:0] v, int hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic int coarse_nx();
		int n;
		n = clamp_dim(cfg_fw, MAX_W);
		return cfg_cx ? (n + 1) / 2 : n;
	endfunction

	function automatic int coarse_ny();
		int n;
		n = clamp_dim(cfg_fh, MAX_H);
		return cfg_cy ? (n + 1) / 2 : n;
	endfunction

	// Fine index (1-based) of one stencil tap along an axis
	function automatic int axis_tap(int c, int n, int nc, logic cz, logic wlo,
			logic whi, mgfw_pkg::tap_t t);
		int centre;
		centre = cz ? 2 * c - 1 : c;
		if (c == 1) begin
			case (t)
				mgfw_pkg::TAP_LO:  return wlo ? n - 1 : 2;
				mgfw_pkg::TAP_MID: return 1;
				default:           return 2;
			endcase
		end else if (c == nc) begin
			case (t)
				mgfw_pkg::TAP_LO:  return n - 1;
				mgfw_pkg::TAP_MID: return n;
				default:           return whi ? 2 : n - 1;
			endcase
		end
		case (t)
			mgfw_pkg::TAP_LO:  return centre - 1;
			mgfw_pkg::TAP_MID: return centre;
			default:           return centre + 1;
		endcase
	endfunction

	function automatic int tap_x(int c, mgfw_pkg::tap_t t);
		return axis_tap(c, clamp_dim(cfg_fw, MAX_W), coarse_nx(), cfg_cx, cfg_wxl,
			cfg_wxh, t);
	endfunction

	function automatic int tap_y(int c, mgfw_pkg::tap_t t);
		return axis_tap(c, clamp_dim(cfg_fh, MAX_H), coarse_ny(), cfg_cy, cfg_wyl,
			cfg_wyh, t);
	endfunction

	function automatic int grid_addr(int x, int y);
		return (y - 1) * MAX_W + (x - 1);
	endfunction

	function automatic bit coarse_inside(int x, int y);
		return x >= 1 && x <= coarse_nx() && y >= 1 && y <= coarse_ny();
	endfunction

	function automatic bit fine_inside(int x, int y);
		return x >= 1 && x <= MAX_W && y >= 1 && y <= MAX_H;
	endfunction

	// Weighted 3x3 sum, floored by 4 bits
	function automatic coarse_t restrict_point(int x, int y);
		coarse_t r;
		longint  acc;
		int      wgt;
		r = '0;
		acc = 0;
		if (!coarse_inside(x, y)) begin
			r.err = 1'b1;
			return r;
		end
		for (int b = 0; b < 3; b++)
			for (int a = 0; a < 3; a++) begin
				wgt = (a == int'(mgfw_pkg::TAP_MID) ? 2 : 1) *
					(b == int'(mgfw_pkg::TAP_MID) ? 2 : 1);
				acc += wgt * longint'(signed'(fine_store[grid_addr(
					tap_x(x, mgfw_pkg::tap_t'(a)), tap_y(y, mgfw_pkg::tap_t'(b)))]));
			end
		r.value = 32'(acc >>> 4);
		return r;
	endfunction

	// Update the shadow state for one accepted beat
	task automatic absorb_beat(input logic act, input logic [6:0] x, input logic [6:0] y,
			input logic [31:0] smp, input logic known, input logic [31:0] k_value,
			input logic k_err);
		coarse_t c;
		beats_counted++;
		if (act == ACT_LOAD) begin
			if (fine_inside(x, y)) begin
				fine_store[grid_addr(x, y)] = smp;
				loaded[grid_addr(x, y)] = 1'b1;
			end
		end else begin
			c = restrict_point(x, y);
			if (known) begin
				c.value = k_value;
				c.err = k_err;
			end
			pending_coarse.push_back(c);
		end
	endtask

	// ---------------- stimulus ----------------

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 7))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0;
			3:       return 32'hFFFF_FFFF;
			4:       return 32'($urandom_range(0, 63)) - 32'd32;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [6:0] pick_coarse(int nc);
		case ($urandom_range(0, 3))
			0:       return 7'd1;
			1:       return 7'(nc);
			default: return 7'($urandom_range(1, nc));
		endcase
	endfunction

	// Offer one beat in sender bursts; a compute first gets its taps loaded
	task automatic offer_beat(input logic act, input logic [6:0] x, input logic [6:0] y,
			input logic [31:0] smp, input logic known, input logic [31:0] k_value,
			input logic k_err);
		int fx, fy;
		if (act == ACT_COMPUTE && coarse_inside(x, y)) begin
			for (int b = 0; b < 3; b++)
				for (int a = 0; a < 3; a++) begin
					fx = tap_x(x, mgfw_pkg::tap_t'(a));
					fy = tap_y(y, mgfw_pkg::tap_t'(b));
					if (!loaded[grid_addr(fx, fy)])
						offer_beat(ACT_LOAD, 7'(fx), 7'(fy), rand_sample(), 1'b0, 32'h0,
							1'b0);
				end
		end
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {2'b00, smp, y, x};
		do
			@(posedge clk);
		while (!s_tready);
		absorb_beat(act, x, y, smp, known, k_value, k_err);
	endtask

	task automatic random_beat();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			offer_beat(ACT_COMPUTE, pick_coarse(coarse_nx()), pick_coarse(coarse_ny()),
				$urandom, 1'b0, 32'h0, 1'b0);
		else if (pick < 85)
			offer_beat(ACT_LOAD, 7'($urandom_range(1, clamp_dim(cfg_fw, MAX_W))),
				7'($urandom_range(1, clamp_dim(cfg_fh, MAX_H))), rand_sample(), 1'b0,
				32'h0, 1'b0);
		else
			offer_beat(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)), $urandom, 1'b0, 32'h0, 1'b0);
	endtask

	// Stop sending and let every outstanding result drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_coarse.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [mgfw_pkg::CFG_IDX_W-1:0] idx, input logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input setting_t s);
		put_reg(mgfw_pkg::REG_FINE_WIDTH, s.fw);
		put_reg(mgfw_pkg::REG_FINE_HEIGHT, s.fh);
		put_reg(mgfw_pkg::REG_COARSEN_X, {6'b0, s.cx});
		put_reg(mgfw_pkg::REG_COARSEN_Y, {6'b0, s.cy});
		put_reg(mgfw_pkg::REG_WRAP_X_LOW, {6'b0, s.wxl});
		put_reg(mgfw_pkg::REG_WRAP_X_HIGH, {6'b0, s.wxh});
		put_reg(mgfw_pkg::REG_WRAP_Y_LOW, {6'b0, s.wyl});
		put_reg(mgfw_pkg::REG_WRAP_Y_HIGH, {6'b0, s.wyh});
		cfg_we <= 1'b0;
		cfg_fw = s.fw;
		cfg_fh = s.fh;
		cfg_cx = s.cx;
		cfg_cy = s.cy;
		cfg_wxl = s.wxl;
		cfg_wxh = s.wxh;
		cfg_wyl = s.wyl;
		cfg_wyh = s.wyh;
	endtask

	// ---------------- output side ----------------

	function automatic void flag(string msg);
		fail_count++;
		$display("%0t: %s", $time, msg);
	endfunction

	// Receiver: stretches of random ready patterns, plus a long hold on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		m_tready = 1'b0;
		mode = RX_FULL;
		mode_left = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left == 0 && hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					RX_FULL: m_tready <= 1'b1;
					RX_HALF: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	// Compare each output beat with the oldest expectation
	always @(posedge clk) begin
		coarse_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_coarse.size() == 0) begin
				flag($sformatf("unexpected result: expected none, actual value %h err %b",
					m_tdata, m_tuser));
			end else begin
				want = pending_coarse.pop_front();
				if (m_tdata !== want.value)
					flag($sformatf("coarse_value: expected %h, actual %h",
						want.value, m_tdata));
				if (m_tuser !== want.err)
					flag($sformatf("index_error: expected %b, actual %b",
						want.err, m_tuser));
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		setting_t s;
		int       target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset settings
		foreach (directed_rows[i])
			offer_beat(directed_rows[i].act, directed_rows[i].x, directed_rows[i].y,
				directed_rows[i].smp, directed_rows[i].known, directed_rows[i].k_value,
				directed_rows[i].k_err);

		// random phases, each under its own register setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			if (ph < NUM_PHASES - 1) begin
				s = phase_settings[ph];
			end else begin
				s.fw = 7'($urandom_range(0, 127));
				s.fh = 7'($urandom_range(0, 127));
				{s.cx, s.cy, s.wxl, s.wxh, s.wyl, s.wyh} = 6'($urandom_range(0, 63));
			end
			program_regs(s);
			// receiver holds off while the sender keeps going
			if (ph % 3 == 1)
				hold_req = 1'b1;
			target = beats_counted + BEATS_PER_PHASE;
			while (beats_counted < target)
				random_beat();
		end

		settle();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#12_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* multigrid_full_weighting_restrict.f */
+incdir+rtl/core
rtl/core/mgfw_pkg.sv
rtl/core/mgfw_ram.sv
rtl/core/mgfw_axis.sv
rtl/core/mgfw_datapath.sv
rtl/core/mgfw_ctrl.sv
rtl/core/multigrid_full_weighting_restrict.sv
rtl/core/mgfw_checker.sv
verif/multigrid_full_weighting_restrict_test.sv
